@@ design/cfd_pkg.sv @@
`default_nettype none

package cfd_pkg;

  // Width of the payload length and of the payload byte counter.
  localparam int unsigned LengthBits = 32;

  // Header byte positions. Position 6 is the payload phase.
  localparam logic [2:0] PosStart   = 3'd0;
  localparam logic [2:0] PosCommand = 3'd1;
  localparam logic [2:0] PosLen0    = 3'd2;
  localparam logic [2:0] PosLen1    = 3'd3;
  localparam logic [2:0] PosLen3    = 3'd5;
  localparam logic [2:0] PosPayload = 3'd6;

  // Command byte codes.
  localparam logic [7:0] CmdPush     = 8'h01;
  localparam logic [7:0] CmdPushJson = 8'h02;
  localparam logic [7:0] CmdNoop     = 8'h09;
  localparam logic [7:0] CmdFlush    = 8'h0A;
  localparam logic [7:0] CmdGet      = 8'h0B;
  localparam logic [7:0] CmdSet      = 8'h0C;

  typedef enum logic [1:0] {
    RoleHeader  = 2'd0,
    RolePayload = 2'd1,
    RoleDiscard = 2'd2
  } byte_role_e;

  typedef enum logic [2:0] {
    FrameFlush    = 3'd0,
    FrameNoop     = 3'd1,
    FrameSet      = 3'd2,
    FrameGet      = 3'd3,
    FramePush     = 3'd4,
    FramePushJson = 3'd5,
    FrameUnknown  = 3'd6
  } frame_type_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_last;
  } cfd_in_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    byte_role_e  byte_role;
    frame_type_e frame_type;
    logic        frame_end;
    logic        bad_command;
  } cfd_out_t;

  // Maps a command byte to its frame type.
  function automatic frame_type_e decode_command(logic [7:0] cmd);
    frame_type_e kind;
    unique case (cmd)
      CmdFlush:    kind = FrameFlush;
      CmdNoop:     kind = FrameNoop;
      CmdSet:      kind = FrameSet;
      CmdGet:      kind = FrameGet;
      CmdPush:     kind = FramePush;
      CmdPushJson: kind = FramePushJson;
      default:     kind = FrameUnknown;
    endcase
    return kind;
  endfunction

endpackage

`default_nettype wire

@@ design/command_frame_deframer.sv @@
// Each accepted byte passes the input register, the parser and the output register.
// Throughput: one byte per cycle while out_stall_i is low; the parser state updates
// in a single pass per byte. The input and output registers decouple the channels,
// so an empty input register still takes a byte while a result waits on a stalled output.
// Reset: asynchronous, active low; the parser returns to frame start, pipeline empty.
`default_nettype none

module command_frame_deframer import cfd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire cfd_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output cfd_out_t      out_data_o
);

  logic     in_valid_q;
  cfd_in_t  in_data_q;
  logic     out_valid_q;
  cfd_out_t out_data_q;
  cfd_out_t result;
  logic     out_ready;
  logic     in_ready;
  logic     fire;

  // Handshake between the input register, the parser and the output register.
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_ready;
  assign in_ready   = !in_valid_q || fire;
  assign in_stall_o = !in_ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready) begin
      in_data_q <= in_data_i;
    end
  end

  cfd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (in_data_q),
    .fire_i   (fire),
    .result_o (result)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

@@ design/cfd_core.sv @@
`default_nettype none

module cfd_core import cfd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cfd_in_t  item_i,
  input  wire logic     fire_i,
  output cfd_out_t      result_o
);

  logic [2:0]            pos_q, pos_d;
  frame_type_e           kind_q, kind_d;
  logic [LengthBits-1:0] len_q, len_d;
  logic [LengthBits-1:0] remaining_q, remaining_d;
  logic                  discard_q, discard_d;

  logic [LengthBits-1:0] rem_dec;
  logic [LengthBits-1:0] len_new;
  logic [31:0]           len_wide;
  logic [4:0]            lane_shift;
  logic                  header_done;
  frame_type_e           cmd_kind;

  // Parser state is committed only when a transaction moves to the output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= PosStart;
      kind_q      <= FrameFlush;
      len_q       <= '0;
      remaining_q <= '0;
      discard_q   <= 1'b0;
    end else if (fire_i) begin
      pos_q       <= pos_d;
      kind_q      <= kind_d;
      len_q       <= len_d;
      remaining_q <= remaining_d;
      discard_q   <= discard_d;
    end
  end

  // Length byte merge: set/get shift in big-endian 16 bits, push and push
  // JSON fill little-endian byte lanes.
  always_comb begin
    lane_shift = {pos_q[1:0] - PosLen0[1:0], 3'b000};
    len_wide   = 32'(len_q) | (32'(item_i.data_byte) << lane_shift);
    if (kind_q == FrameSet || kind_q == FrameGet) begin
      len_new     = LengthBits'({len_q[7:0], item_i.data_byte});
      header_done = (pos_q == PosLen1);
    end else begin
      len_new     = len_wide[LengthBits-1:0];
      header_done = (pos_q == PosLen3);
    end
  end

  assign rem_dec  = remaining_q - LengthBits'(1);
  assign cmd_kind = decode_command(item_i.data_byte);

  // Next state and result for the byte in the input register.
  always_comb begin
    pos_d       = pos_q;
    kind_d      = kind_q;
    len_d       = len_q;
    remaining_d = remaining_q;
    discard_d   = discard_q;

    result_o.byte_out    = item_i.data_byte;
    result_o.byte_role   = RoleHeader;
    result_o.frame_type  = FrameUnknown;
    result_o.frame_end   = 1'b0;
    result_o.bad_command = 1'b0;

    if (discard_q) begin
      result_o.byte_role = RoleDiscard;
      if (item_i.chunk_last) begin
        discard_d = 1'b0;
        pos_d     = PosStart;
      end
    end else if (pos_q == PosPayload) begin
      result_o.byte_role  = RolePayload;
      result_o.frame_type = kind_q;
      remaining_d         = rem_dec;
      if (rem_dec == '0) begin
        result_o.frame_end = 1'b1;
        pos_d              = PosStart;
      end
    end else if (pos_q == PosCommand) begin
      len_d = '0;
      if (cmd_kind == FrameUnknown) begin
        result_o.byte_role   = RoleDiscard;
        result_o.bad_command = 1'b1;
        pos_d                = PosStart;
        discard_d            = !item_i.chunk_last;
      end else begin
        kind_d              = cmd_kind;
        result_o.frame_type = cmd_kind;
        if (cmd_kind == FrameFlush || cmd_kind == FrameNoop) begin
          result_o.frame_end = 1'b1;
          pos_d              = PosStart;
        end else begin
          pos_d = PosLen0;
        end
      end
    end else if (pos_q >= PosLen0 && pos_q <= PosLen3) begin
      result_o.frame_type = kind_q;
      len_d               = len_new;
      if (header_done) begin
        if (len_new == '0) begin
          result_o.frame_end = 1'b1;
          pos_d              = PosStart;
        end else begin
          remaining_d = len_new;
          pos_d       = PosPayload;
        end
      end else begin
        pos_d = pos_q + 3'd1;
      end
    end else begin
      // Frame start, including the unused position seven.
      pos_d = PosCommand;
    end
  end

endmodule

`default_nettype wire

@@ dv/tb_command_frame_deframer.sv @@
`timescale 1ns / 100ps

module tb_command_frame_deframer;
  import cfd_pkg::*;

  localparam int unsigned PHASE_BYTES = 500;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned DIR_ROWS    = 31;
  localparam logic [31:0] LEN_MASK    = 32'((64'd1 << LengthBits) - 64'd1);

  // One row of the directed table. Rows with known_tag set carry their result.
  typedef struct {
    logic [7:0]  bt;
    logic        last;
    bit          known_tag;
    byte_role_e  role;
    frame_type_e kind;
    logic        fend;
    logic        bad;
  } dir_row_t;

  logic     clk_i;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  cfd_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  cfd_out_t out_data;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned bytes_accepted = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // Expected byte tags, oldest first.
  cfd_out_t expected_tags[$];
  dir_row_t dir_tab[DIR_ROWS];

  // Parser state mirrored by the predictor.
  logic [2:0]  hdr_pos;
  frame_type_e cur_kind;
  logic [31:0] len_acc;
  logic [31:0] pay_left;
  logic        dropping;

  command_frame_deframer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Frame type of a command byte; anything else is unknown.
  function automatic frame_type_e kind_of(logic [7:0] cmd);
    case (cmd)
      CmdFlush:    return FrameFlush;
      CmdNoop:     return FrameNoop;
      CmdSet:      return FrameSet;
      CmdGet:      return FrameGet;
      CmdPush:     return FramePush;
      CmdPushJson: return FramePushJson;
      default:     return FrameUnknown;
    endcase
  endfunction

  // Computes the tag of one stream byte and advances the mirrored parser.
  function automatic cfd_out_t tag_byte(cfd_in_t item);
    cfd_out_t    res;
    frame_type_e k;
    logic [2:0]  last_pos;
    logic [31:0] len;
    res.byte_out    = item.data_byte;
    res.byte_role   = RoleHeader;
    res.frame_type  = FrameUnknown;
    res.frame_end   = 1'b0;
    res.bad_command = 1'b0;
    if (dropping) begin
      res.byte_role = RoleDiscard;
      if (item.chunk_last) begin
        dropping = 1'b0;
        hdr_pos  = PosStart;
      end
    end else if (hdr_pos == PosPayload) begin
      res.byte_role  = RolePayload;
      res.frame_type = cur_kind;
      pay_left       = pay_left - 32'd1;
      if (pay_left == '0) begin
        res.frame_end = 1'b1;
        hdr_pos       = PosStart;
      end
    end else if (hdr_pos == PosCommand) begin
      k       = kind_of(item.data_byte);
      len_acc = '0;
      if (k == FrameUnknown) begin
        res.byte_role   = RoleDiscard;
        res.bad_command = 1'b1;
        hdr_pos         = PosStart;
        dropping        = !item.chunk_last;
      end else begin
        cur_kind       = k;
        res.frame_type = k;
        if (k == FrameFlush || k == FrameNoop) begin
          res.frame_end = 1'b1;
          hdr_pos       = PosStart;
        end else begin
          hdr_pos = PosLen0;
        end
      end
    end else if (hdr_pos >= PosLen0 && hdr_pos <= PosLen3) begin
      res.frame_type = cur_kind;
      // Set and get carry a big-endian 16-bit length, push a little-endian 32-bit one.
      if (cur_kind == FrameSet || cur_kind == FrameGet) begin
        len_acc  = {16'h0000, len_acc[7:0], item.data_byte};
        last_pos = PosLen1;
      end else begin
        len_acc[8 * (hdr_pos - PosLen0) +: 8] = item.data_byte;
        last_pos = PosLen3;
      end
      if (hdr_pos == last_pos) begin
        len = len_acc & LEN_MASK;
        if (len == '0) begin
          res.frame_end = 1'b1;
          hdr_pos       = PosStart;
        end else begin
          pay_left = len;
          hdr_pos  = PosPayload;
        end
      end else begin
        hdr_pos = hdr_pos + 3'd1;
      end
    end else begin
      hdr_pos = PosCommand;
    end
    return res;
  endfunction

  // Offers one byte, waits for the transaction and records its expected tag.
  task automatic send_byte(input cfd_in_t item, input bit known_tag, input cfd_out_t fixed_tag);
    cfd_out_t tag;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk_i); while (in_stall);
    tag = tag_byte(item);
    expected_tags.push_back(known_tag ? fixed_tag : tag);
    bytes_accepted++;
    @(negedge clk_i);
  endtask

  // Sends a byte whose chunk mark is random.
  task automatic send_plain(input logic [7:0] bt);
    send_byte('{data_byte: bt, chunk_last: ($urandom_range(7) == 0)}, 1'b0, '0);
  endtask

  // Builds one random frame; a few carry an unknown command, mostly with a discarded tail.
  task automatic send_frame();
    int unsigned pick;
    int unsigned plen;
    int unsigned ndrop;
    logic [7:0]  cmd;
    logic        last;
    pick = $urandom_range(99);
    send_plain(8'($urandom_range(255)));
    if (pick < 10) begin
      do cmd = 8'($urandom_range(255)); while (kind_of(cmd) != FrameUnknown);
      last = ($urandom_range(3) == 0);
      send_byte('{data_byte: cmd, chunk_last: last}, 1'b0, '0);
      if (!last) begin
        ndrop = $urandom_range(6);
        repeat (ndrop) send_byte('{data_byte: 8'($urandom_range(255)), chunk_last: 1'b0}, 1'b0, '0);
        send_byte('{data_byte: 8'($urandom_range(255)), chunk_last: 1'b1}, 1'b0, '0);
      end
    end else begin
      case (pick % 6)
        0:       cmd = CmdFlush;
        1:       cmd = CmdNoop;
        2:       cmd = CmdSet;
        3:       cmd = CmdGet;
        4:       cmd = CmdPush;
        default: cmd = CmdPushJson;
      endcase
      send_plain(cmd);
      // Mostly short payloads, now and then a long one.
      plen = ($urandom_range(29) == 0) ? $urandom_range(400) : $urandom_range(12);
      if (cmd == CmdSet || cmd == CmdGet) begin
        send_plain(8'(plen >> 8));
        send_plain(8'(plen));
      end else if (cmd == CmdPush || cmd == CmdPushJson) begin
        for (int i = 0; i < 4; i++) send_plain(8'(plen >> (8 * i)));
      end
      if (cmd != CmdFlush && cmd != CmdNoop) begin
        repeat (plen) send_plain(8'($urandom_range(255)));
      end
    end
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Result checker.
  always @(posedge clk_i) begin : result_monitor
    cfd_out_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_tags.size() == 0) begin
        $error("unexpected result transaction, byte_out %0h", out_data.byte_out);
        mismatch_count++;
      end else begin
        want = expected_tags.pop_front();
        check_field("byte_out", want.byte_out, out_data.byte_out);
        check_field("byte_role", 8'(want.byte_role), 8'(out_data.byte_role));
        check_field("frame_type", 8'(want.frame_type), 8'(out_data.frame_type));
        check_field("frame_end", 8'(want.frame_end), 8'(out_data.frame_end));
        check_field("bad_command", 8'(want.bad_command), 8'(out_data.bad_command));
      end
    end
  end

  // Receiver stalls; a hold request keeps the output stalled for a long stretch.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("command_frame_deframer verification failed");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin : stimulus
    int unsigned phase_base;
    cfd_out_t    fixed_tag;
    hdr_pos  = PosStart;
    cur_kind = FrameFlush;
    len_acc  = '0;
    pay_left = '0;
    dropping = 1'b0;

    // Directed frames: every command, zero and short lengths, an unknown command.
    dir_tab = '{
      '{8'h00,       1'b0, 1'b1, RoleHeader,  FrameUnknown,  1'b0, 1'b0},
      '{CmdFlush,    1'b0, 1'b1, RoleHeader,  FrameFlush,    1'b1, 1'b0},
      '{8'hFF,       1'b0, 1'b0, RoleHeader,  FrameUnknown,  1'b0, 1'b0},
      '{CmdNoop,     1'b1, 1'b1, RoleHeader,  FrameNoop,     1'b1, 1'b0},
      '{8'h5A,       1'b0, 1'b0, RoleHeader,  FrameUnknown,  1'b0, 1'b0},
      '{CmdSet,      1'b0, 1'b0, RoleHeader,  FrameUnknown,  1'b0, 1'b0},
      '{8'h00,       1'b0, 1'b0, RoleHeader,  FrameUnknown,  1'b0, 1'b0},
      '{8'h00,       1'b0, 1'b1, RoleHeader,  FrameSet,      1'b1, 1'b0},
      '{8'hC3,       1'b0, 1'b0, RoleHeader,  FrameUnknown,  1'b0, 1'b0},
      '{CmdGet,      1'b0, 1'b0, RoleHeader,  FrameUnknown,  1'b0, 1'b0},
      '{8'h00,       1'b0, 1'b0, RoleHeader,  FrameUnknown,  1'b0, 1'b0},
      '{8'h02,       1'b0, 1'b0, RoleHeader,  FrameUnknown,  1'b0, 1'b0},
      '{8'hFF,       1'b0, 1'b1, RolePayload, FrameGet,      1'b0, 1'b0},
      '{8'h00,       1'b1, 1'b1, RolePayload, FrameGet,      1'b1, 1'b0},
      '{8'h81,       1'b0, 1'b0, RoleHeader,  FrameUnknown,  1'b0, 1'b0},
      '{CmdPush,     1'b0, 1'b0, RoleHeader,  FrameUnknown,  1'b0, 1'b0},
      '{8'h01,       1'b0, 1'b0, RoleHeader,  FrameUnknown,  1'b0, 1'b0},
      '{8'h00,       1'b1, 1'b0, RoleHeader,  FrameUnknown,  1'b0, 1'b0},
      '{8'h00,       1'b0, 1'b0, RoleHeader,  FrameUnknown,  1'b0, 1'b0},
      '{8'h00,       1'b0, 1'b0, RoleHeader,  FrameUnknown,  1'b0, 1'b0},
      '{8'hA5,       1'b0, 1'b1, RolePayload, FramePush,     1'b1, 1'b0},
      '{8'h3C,       1'b0, 1'b0, RoleHeader,  FrameUnknown,  1'b0, 1'b0},
      '{CmdPushJson, 1'b0, 1'b0, RoleHeader,  FrameUnknown,  1'b0, 1'b0},
      '{8'h00,       1'b0, 1'b0, RoleHeader,  FrameUnknown,  1'b0, 1'b0},
      '{8'h00,       1'b0, 1'b0, RoleHeader,  FrameUnknown,  1'b0, 1'b0},
      '{8'h00,       1'b0, 1'b0, RoleHeader,  FrameUnknown,  1'b0, 1'b0},
      '{8'h00,       1'b0, 1'b1, RoleHeader,  FramePushJson, 1'b1, 1'b0},
      '{8'h66,       1'b0, 1'b0, RoleHeader,  FrameUnknown,  1'b0, 1'b0},
      '{8'hFF,       1'b0, 1'b1, RoleDiscard, FrameUnknown,  1'b0, 1'b1},
      '{8'h12,       1'b0, 1'b0, RoleHeader,  FrameUnknown,  1'b0, 1'b0},
      '{8'hFE,       1'b1, 1'b1, RoleDiscard, FrameUnknown,  1'b0, 1'b0}
    };

    // Reset, released at a falling edge.
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 27;
    recv_idle_pct = 57;
    foreach (dir_tab[i]) begin
      fixed_tag = '{byte_out: dir_tab[i].bt, byte_role: dir_tab[i].role,
                    frame_type: dir_tab[i].kind, frame_end: dir_tab[i].fend,
                    bad_command: dir_tab[i].bad};
      send_byte('{data_byte: dir_tab[i].bt, chunk_last: dir_tab[i].last},
                dir_tab[i].known_tag, fixed_tag);
    end

    // Random frames in three idling phases; the last one opens with a long output hold.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 27;
          recv_idle_pct = 57;
        end
        1: begin
          send_idle_pct = 57;
          recv_idle_pct = 27;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_req      = 1'b1;
        end
      endcase
      phase_base = bytes_accepted;
      while (bytes_accepted - phase_base < PHASE_BYTES) send_frame();
    end
    in_valid <= 1'b0;

    // Drain, then let the pipeline settle.
    while (expected_tags.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("command_frame_deframer verification clean");
    end else begin
      $display("command_frame_deframer verification failed");
    end
    $finish;
  end

endmodule

@@ command_frame_deframer.f @@
design/cfd_pkg.sv
design/cfd_core.sv
design/command_frame_deframer.sv
dv/tb_command_frame_deframer.sv
